>>> rtl/cdq_pkg.sv
// Shared types and constants for the circular deque.
package cdq_pkg;

    localparam int DEFAULT_DEPTH = 8;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 4;

    // Value returned by a pop from an empty deque
    localparam logic signed [DATA_W-1:0] POP_EMPTY_VALUE = -32'sd1;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_req;
        logic exec;
        logic load_out;
    } t_dp_cmd;

endpackage

>>> rtl/cdq_ifs.sv
// Request and response channel interfaces of the circular deque.
interface cdq_req_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface cdq_rsp_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output pop_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input occupancy,
                    output ready);
endinterface

>>> rtl/circular_deque.sv
// Circular double-ended queue: top level joining controller and datapath.
//
// Usage:
//   i_req carries one request per transfer: action (0 push front, 1 push
//   rear, 2 pop front, 3 pop rear) and push_value (ignored on pops).
//   o_rsp returns exactly one result per request, in order: pop_value
//   (popped entry, -1 on underflow, 0 on any push), status (0 ok,
//   1 overflow, 2 underflow) and occupancy after the step (low 4 bits).
//   A push into a full deque or a pop from an empty one changes nothing.
// Timing:
//   A request is taken in the idle state, executed in the next cycle
//   (pointer update plus one slot memory access), and its result is
//   loaded into the output register from the done state once that
//   register is free. A new request is taken only in the idle state,
//   after the previous result has been loaded. The registered read of
//   the slot memory makes the load a separate step after execution.
// Reset and stall:
//   Synchronous active-low reset empties the deque; slot contents are not
//   cleared and no clearing pass is needed. While the receiver holds off,
//   one further request is still taken and executed; it then waits in the
//   done state until the output register is free.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdq_req_if.sink   i_req,
    cdq_rsp_if.source o_rsp
);
    import cdq_pkg::*;

    t_dp_cmd w_cmd;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_action     (i_req.action),
        .i_push_value (i_req.push_value),
        .o_pop_value  (o_rsp.pop_value),
        .o_status     (o_rsp.status),
        .o_occupancy  (o_rsp.occupancy)
    );

endmodule

>>> rtl/cdq_ctrl.sv
// Controller state machine: sequences request capture, execution and result load.
module cdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_rsp_ready,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    output cdq_pkg::t_dp_cmd o_cmd
);
    import cdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd w_cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    w_cmd.take_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                w_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_rsp_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output register valid flag
    always_comb begin
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_cmd       = w_cmd;

`ifndef NO_ASSERTIONS
    // execution always comes in the cycle after a request transfer
    a_exec_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> $past(w_cmd.take_req))
        else $error("exec without preceding request transfer");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!r_out_valid || i_rsp_ready))
        else $error("result register overwritten");

    // a new result shows up only after the done state
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result valid raised outside done state");
`endif

endmodule

>>> rtl/cdq_dp.sv
// Datapath: request registers, pointers, count, slot memory and result register.
module cdq_dp #(
    parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cdq_pkg::t_dp_cmd                 i_cmd,
    input  logic [1:0]                       i_action,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_push_value,
    output logic signed [cdq_pkg::DATA_W-1:0] o_pop_value,
    output logic [1:0]                       o_status,
    output logic [cdq_pkg::OCC_W-1:0]        o_occupancy
);
    import cdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // Captured request
    t_action                  r_action;
    logic signed [DATA_W-1:0] r_push_value;

    // Deque control state
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    // Step result held until load
    t_status r_status, n_status;
    logic    r_pop_ok;

    // Slot memory
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              w_wr_en, w_rd_en;
    logic [IDX_W-1:0]  w_wr_addr, w_rd_addr;

    // Output register
    logic signed [DATA_W-1:0] r_out_pop_value, n_out_pop_value;
    t_status                  r_out_status;
    logic [OCC_W-1:0]         r_out_occ;

    logic             w_is_push, w_empty, w_full;
    logic [IDX_W-1:0] w_head_inc, w_head_dec, w_tail_inc, w_tail_dec;

    assign w_is_push  = (r_action == ACT_PUSH_FRONT) || (r_action == ACT_PUSH_REAR);
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == FULL_CNT);
    assign w_head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign w_head_dec = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign w_tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign w_tail_dec = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;

    // Step execution: pointer, count and memory access
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_status  = ST_OK;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;
        w_wr_addr = '0;
        w_rd_addr = r_head;
        if (i_cmd.exec) begin
            if (w_is_push) begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    w_wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                    if (w_empty) begin
                        n_head    = '0;
                        n_tail    = '0;
                        w_wr_addr = '0;
                    end else if (r_action == ACT_PUSH_FRONT) begin
                        n_head    = w_head_dec;
                        w_wr_addr = w_head_dec;
                    end else begin
                        n_tail    = w_tail_inc;
                        w_wr_addr = w_tail_inc;
                    end
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    w_rd_en = 1'b1;
                    n_count = r_count - 1'b1;
                    if (r_action == ACT_POP_FRONT) begin
                        w_rd_addr = r_head;
                        n_head    = w_head_inc;
                    end else begin
                        w_rd_addr = r_tail;
                        n_tail    = w_tail_dec;
                    end
                    // last entry gone: pointers go home
                    if (r_count == CNT_W'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                end
            end
        end
    end

    // Result payload selection
    always_comb begin
        if (r_pop_ok) begin
            n_out_pop_value = r_rd_data;
        end else if (r_status == ST_UNDERFLOW) begin
            n_out_pop_value = POP_EMPTY_VALUE;
        end else begin
            n_out_pop_value = '0;
        end
    end

    // Control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_action     <= t_action'(i_action);
            r_push_value <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= w_rd_en;
        end
        if (i_cmd.load_out) begin
            r_out_pop_value <= n_out_pop_value;
            r_out_status    <= r_status;
            r_out_occ       <= OCC_W'(r_count);
        end
    end

    // Slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= r_push_value;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_pop_value = r_out_pop_value;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;

`ifndef NO_ASSERTIONS
    // count never exceeds the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond depth");

    // an empty deque has both pointers at slot zero
    a_empty_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty deque with pointers away from zero");

    // refused push or underflow pop leaves the count alone
    a_refused_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && ((w_is_push && w_full) || (!w_is_push && w_empty)))
            |=> $stable(r_count) && $stable(r_head) && $stable(r_tail))
        else $error("refused request changed deque state");
`endif

endmodule
